// ===== hw/rtl/madi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package madi_pkg;

	// Fields produced by the first stage: gathered samples, partial scores and candidates.
	typedef struct packed {
		logic [7:0]         c;
		logic [7:0]         e;
		logic [7:0]         d;
		logic [7:0]         b;
		logic [7:0]         f;
		logic [7:0]         td0;
		logic [7:0]         td1;
		logic [7:0]         td2;
		logic signed [10:0] score0;
		logic [9:0]         sm1;
		logic [9:0]         sm2;
		logic [9:0]         sp1;
		logic [9:0]         sp2;
		logic [7:0]         pv0;
		logic [7:0]         pm1;
		logic [7:0]         pm2;
		logic [7:0]         pp1;
		logic [7:0]         pp2;
	} madi_s1_t;

	// Spatial prediction and temporal bound handed to the clamp stage.
	typedef struct packed {
		logic [7:0] pred;
		logic [7:0] d;
		logic [7:0] diff;
	} madi_s3_t;

	localparam logic [1:0] MODE_NO_SPATIAL = 2'd2;

	function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8:1];
	endfunction

	function automatic logic [9:0] sum3(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		return {2'b00, a} + {2'b00, b} + {2'b00, c};
	endfunction

	function automatic logic signed [9:0] sdiff8(input logic [7:0] a, input logic [7:0] b);
		return $signed({2'b00, a}) - $signed({2'b00, b});
	endfunction

	function automatic logic signed [9:0] smax(input logic signed [9:0] a,
			input logic signed [9:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic signed [9:0] smin(input logic signed [9:0] a,
			input logic signed [9:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/madi_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module madi_front import madi_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        field_select,
	input  wire logic [39:0] prev_column,
	input  wire logic [39:0] next_column,
	input  wire logic [55:0] cur_above,
	input  wire logic [55:0] cur_below,
	input  wire logic [23:0] cur_column,
	output logic             valid_s1,
	output madi_s1_t         data_s1
);

	logic [7:0] ab [7];
	logic [7:0] be [7];
	logic [7:0] pv [5];
	logic [7:0] nx [5];
	logic [7:0] cc [3];
	logic [7:0] p2m, p20, p2p, n2m, n20, n2p;
	logic [8:0] td1_sum, td2_sum;
	logic [9:0] base_sum;
	madi_s1_t   nxt;

	always_comb begin
		for (int k = 0; k < 7; k++) begin
			ab[k] = cur_above[8*k +: 8];
			be[k] = cur_below[8*k +: 8];
		end
		for (int k = 0; k < 5; k++) begin
			pv[k] = prev_column[8*k +: 8];
			nx[k] = next_column[8*k +: 8];
		end
		for (int k = 0; k < 3; k++) begin
			cc[k] = cur_column[8*k +: 8];
		end
	end

	always_comb begin
		if (field_select) begin
			p2m = pv[0]; p20 = pv[2]; p2p = pv[4];
			n2m = cc[0]; n20 = cc[1]; n2p = cc[2];
		end else begin
			p2m = cc[0]; p20 = cc[1]; p2p = cc[2];
			n2m = nx[0]; n20 = nx[2]; n2p = nx[4];
		end

		td1_sum  = {1'b0, abs_diff8(pv[1], ab[3])} + {1'b0, abs_diff8(pv[3], be[3])};
		td2_sum  = {1'b0, abs_diff8(nx[1], ab[3])} + {1'b0, abs_diff8(nx[3], be[3])};
		base_sum = sum3(abs_diff8(ab[2], be[2]), abs_diff8(ab[3], be[3]),
			abs_diff8(ab[4], be[4]));

		nxt.c      = ab[3];
		nxt.e      = be[3];
		nxt.d      = avg8(p20, n20);
		nxt.b      = avg8(p2m, n2m);
		nxt.f      = avg8(p2p, n2p);
		nxt.td0    = abs_diff8(p20, n20);
		nxt.td1    = td1_sum[8:1];
		nxt.td2    = td2_sum[8:1];
		nxt.score0 = $signed({1'b0, base_sum}) - 11'sd1;
		// Edge directions pair the row above at +j with the row below at -j.
		nxt.sm1    = sum3(abs_diff8(ab[1], be[3]), abs_diff8(ab[2], be[4]),
			abs_diff8(ab[3], be[5]));
		nxt.sm2    = sum3(abs_diff8(ab[0], be[4]), abs_diff8(ab[1], be[5]),
			abs_diff8(ab[2], be[6]));
		nxt.sp1    = sum3(abs_diff8(ab[3], be[1]), abs_diff8(ab[4], be[2]),
			abs_diff8(ab[5], be[3]));
		nxt.sp2    = sum3(abs_diff8(ab[4], be[0]), abs_diff8(ab[5], be[1]),
			abs_diff8(ab[6], be[2]));
		nxt.pv0    = avg8(ab[3], be[3]);
		nxt.pm1    = avg8(ab[2], be[4]);
		nxt.pm2    = avg8(ab[1], be[5]);
		nxt.pp1    = avg8(ab[4], be[2]);
		nxt.pp2    = avg8(ab[5], be[1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/madi_select.sv =====
`timescale 1ns / 1ps
`default_nettype none
module madi_select import madi_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] mode,
	input  wire logic       valid_s1,
	input  wire madi_s1_t   data_s1,
	output logic            valid_s3,
	output madi_s3_t        data_s3
);

	logic                valid_s2;
	logic signed [10:0]  score_s2;
	logic [7:0]          pred_s2;
	logic [7:0]          diff0_s2;
	logic signed [9:0]   mx_s2, mn_s2;
	logic [9:0]          sp1_s2, sp2_s2;
	logic [7:0]          pp1_s2, pp2_s2, d_s2;

	logic signed [10:0]  score_l;
	logic [7:0]          pred_l, diff0_l, td0_half;
	logic signed [9:0]   de, dc, bc, fe;
	logic [7:0]          pred_r;
	logic signed [9:0]   diff_w;

	// Left-hand edge directions: offset -2 only counts once offset -1 has won.
	always_comb begin
		score_l = data_s1.score0;
		pred_l  = data_s1.pv0;
		if ($signed({1'b0, data_s1.sm1}) < score_l) begin
			score_l = $signed({1'b0, data_s1.sm1});
			pred_l  = data_s1.pm1;
			if (data_s1.sm2 < data_s1.sm1) begin
				score_l = $signed({1'b0, data_s1.sm2});
				pred_l  = data_s1.pm2;
			end
		end

		td0_half = {1'b0, data_s1.td0[7:1]};
		diff0_l  = (td0_half > data_s1.td1) ? td0_half : data_s1.td1;
		diff0_l  = (diff0_l > data_s1.td2) ? diff0_l : data_s1.td2;

		de = sdiff8(data_s1.d, data_s1.e);
		dc = sdiff8(data_s1.d, data_s1.c);
		bc = sdiff8(data_s1.b, data_s1.c);
		fe = sdiff8(data_s1.f, data_s1.e);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		score_s2 <= score_l;
		pred_s2  <= pred_l;
		diff0_s2 <= diff0_l;
		mx_s2    <= smax(smax(de, dc), smin(bc, fe));
		mn_s2    <= smin(smin(de, dc), smax(bc, fe));
		sp1_s2   <= data_s1.sp1;
		sp2_s2   <= data_s1.sp2;
		pp1_s2   <= data_s1.pp1;
		pp2_s2   <= data_s1.pp2;
		d_s2     <= data_s1.d;
	end

	// Right-hand edge directions, then the temporal bound.
	always_comb begin
		pred_r = pred_s2;
		if ($signed({1'b0, sp1_s2}) < score_s2) begin
			pred_r = pp1_s2;
			if (sp2_s2 < sp1_s2) begin
				pred_r = pp2_s2;
			end
		end

		diff_w = $signed({2'b00, diff0_s2});
		if (mode < MODE_NO_SPATIAL) begin
			diff_w = smax(smax(diff_w, mn_s2), -mx_s2);
		end
	end

	always_ff @(posedge clk) begin
		data_s3.pred <= pred_r;
		data_s3.d    <= d_s2;
		data_s3.diff <= diff_w[7:0];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/madi_clamp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module madi_clamp import madi_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       valid_s3,
	input  wire madi_s3_t   data_s3,
	output logic            done,
	output logic [7:0]      pixel_out
);

	logic signed [9:0] hi, lo, pred_x, res;

	always_comb begin
		hi     = $signed({2'b00, data_s3.d}) + $signed({2'b00, data_s3.diff});
		lo     = $signed({2'b00, data_s3.d}) - $signed({2'b00, data_s3.diff});
		pred_x = $signed({2'b00, data_s3.pred});
		if (pred_x > hi) begin
			res = hi;
		end else if (pred_x < lo) begin
			res = lo;
		end else begin
			res = pred_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s3;
		end
	end

	// The bound is never negative, so the clamped value always fits a byte.
	always_ff @(posedge clk) begin
		pixel_out <= res[7:0];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/motion_adaptive_deinterlace_pixel.sv =====
// Yadif-style interpolation of one missing-line pixel per beat. The block takes a new beat in
// every cycle (busy never rises) and returns each pixel on pixel_out with done high for one
// cycle. Stage one gathers samples and scores, stages two and three pick the edge direction
// and build the temporal bound, stage four clamps. Results come out in input order and
// cannot be held off. mode and field_select should only be written while no beat is in
// flight; the configuration port is always ready.
`timescale 1ns / 1ps
`default_nettype none
module motion_adaptive_deinterlace_pixel import madi_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [1:0]  cfg_data,
	input  wire logic [39:0] prev_column,
	input  wire logic [39:0] next_column,
	input  wire logic [55:0] cur_above,
	input  wire logic [55:0] cur_below,
	input  wire logic [23:0] cur_column,
	output logic             done,
	output logic [7:0]       pixel_out
);

	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_FIELD = 1'b1;

	logic [1:0] mode_q;
	logic       field_select_q;
	logic       valid_s1, valid_s3;
	madi_s1_t   data_s1;
	madi_s3_t   data_s3;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= 2'd0;
			field_select_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:  mode_q         <= cfg_data;
				REG_FIELD: field_select_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	madi_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start && !busy),
		.field_select (field_select_q),
		.prev_column  (prev_column),
		.next_column  (next_column),
		.cur_above    (cur_above),
		.cur_below    (cur_below),
		.cur_column   (cur_column),
		.valid_s1     (valid_s1),
		.data_s1      (data_s1)
	);

	madi_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	madi_clamp u_clamp (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s3  (valid_s3),
		.data_s3   (data_s3),
		.done      (done),
		.pixel_out (pixel_out)
	);

endmodule
`default_nettype wire

// ===== tb/madi_tb_pkg.sv =====
`timescale 1ns / 1ps
package madi_tb_pkg;

	// Register indexes on the configuration channel.
	localparam logic REG_MODE         = 1'b0;
	localparam logic REG_FIELD_SELECT = 1'b1;

endpackage

// ===== tb/deinterlace_check.sv =====
`timescale 1ns / 1ps
module deinterlace_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [1:0]  cfg_data,
	input  wire logic [39:0] prev_column,
	input  wire logic [39:0] next_column,
	input  wire logic [55:0] cur_above,
	input  wire logic [55:0] cur_below,
	input  wire logic [23:0] cur_column,
	input  wire logic        done,
	input  wire logic [7:0]  pixel_out,
	output int               mismatches,
	output int               in_flight
);
	import madi_tb_pkg::*;

	logic [1:0] cfg_mode_q;
	logic       cfg_fsel_q;
	logic [7:0] expected_pixels [$];
	logic [7:0] want;

	function automatic int mag(input int a);
		return (a < 0) ? -a : a;
	endfunction

	function automatic int larger(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	function automatic int smaller(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	// Sample of a current-frame row at column offset o (-3..3).
	function automatic int tap(input logic [55:0] row, input int o);
		return int'(row[8 * (o + 3) +: 8]);
	endfunction

	// Sum of absolute differences along the diagonal through the missing pixel.
	function automatic int diag_cost(input logic [55:0] ab, input logic [55:0] be, input int j);
		return mag(tap(ab, j - 1) - tap(be, -1 - j)) + mag(tap(ab, j) - tap(be, -j))
			+ mag(tap(ab, j + 1) - tap(be, 1 - j));
	endfunction

	function automatic logic [7:0] predict_pixel(input logic [39:0] pv, input logic [39:0] nx,
			input logic [55:0] ab, input logic [55:0] be, input logic [23:0] cc,
			input logic [1:0] md, input logic fs);
		int p2m, p20, p2p, n2m, n20, n2p;
		int c, e, d, bound, td0, td1, td2, pred, score, s, b, f, hi, lo;
		if (fs) begin
			p2m = int'(pv[7:0]);
			p20 = int'(pv[23:16]);
			p2p = int'(pv[39:32]);
			n2m = int'(cc[7:0]);
			n20 = int'(cc[15:8]);
			n2p = int'(cc[23:16]);
		end else begin
			p2m = int'(cc[7:0]);
			p20 = int'(cc[15:8]);
			p2p = int'(cc[23:16]);
			n2m = int'(nx[7:0]);
			n20 = int'(nx[23:16]);
			n2p = int'(nx[39:32]);
		end
		c = tap(ab, 0);
		e = tap(be, 0);
		d = (p20 + n20) / 2;
		td0 = mag(p20 - n20);
		td1 = (mag(int'(pv[15:8]) - c) + mag(int'(pv[31:24]) - e)) / 2;
		td2 = (mag(int'(nx[15:8]) - c) + mag(int'(nx[31:24]) - e)) / 2;
		bound = larger(larger(td0 / 2, td1), td2);

		pred = (c + e) / 2;
		score = mag(tap(ab, -1) - tap(be, -1)) + mag(c - e) + mag(tap(ab, 1) - tap(be, 1)) - 1;
		// The wider offset on each side is only tried when the narrow one won.
		s = diag_cost(ab, be, -1);
		if (s < score) begin
			score = s;
			pred = (tap(ab, -1) + tap(be, 1)) / 2;
			s = diag_cost(ab, be, -2);
			if (s < score) begin
				score = s;
				pred = (tap(ab, -2) + tap(be, 2)) / 2;
			end
		end
		s = diag_cost(ab, be, 1);
		if (s < score) begin
			score = s;
			pred = (tap(ab, 1) + tap(be, -1)) / 2;
			s = diag_cost(ab, be, 2);
			if (s < score) begin
				score = s;
				pred = (tap(ab, 2) + tap(be, -2)) / 2;
			end
		end

		if (md < madi_pkg::MODE_NO_SPATIAL) begin
			b = (p2m + n2m) / 2;
			f = (p2p + n2p) / 2;
			hi = larger(larger(d - e, d - c), smaller(b - c, f - e));
			lo = smaller(smaller(d - e, d - c), larger(b - c, f - e));
			bound = larger(larger(bound, lo), -hi);
		end

		if (pred > d + bound)
			pred = d + bound;
		else if (pred < d - bound)
			pred = d - bound;
		return pred[7:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mode_q <= '0;
			cfg_fsel_q <= 1'b0;
			expected_pixels.delete();
			in_flight <= 0;
			mismatches <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE: cfg_mode_q <= cfg_data;
					REG_FIELD_SELECT: cfg_fsel_q <= cfg_data[0];
				endcase
			end
			if (start && !busy)
				expected_pixels.push_back(predict_pixel(prev_column, next_column, cur_above,
					cur_below, cur_column, cfg_mode_q, cfg_fsel_q));
			if (done) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t deinterlace_check: pixel_out %0d arrived with nothing pending",
						$time, pixel_out);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_pixels.pop_front();
					if (pixel_out !== want) begin
						$display("%0t deinterlace_check: pixel_out expected %0d, got %0d",
							$time, want, pixel_out);
						mismatches <= mismatches + 1;
					end
				end
			end
			in_flight <= expected_pixels.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import madi_tb_pkg::*;

	localparam int TIMEOUT_CYCLES = 400000;
	localparam int PHASES = 10;
	localparam int PIXELS_PER_PHASE = 125;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [1:0]  cfg_data;
	logic [39:0] prev_column;
	logic [39:0] next_column;
	logic [55:0] cur_above;
	logic [55:0] cur_below;
	logic [23:0] cur_column;
	logic        done;
	logic [7:0]  pixel_out;
	int          mismatches;
	int          in_flight;
	int          cycle_count = 0;
	logic        steady;

	// Settings for the first eight phases; field_select values above one check that the upper bit is dropped.
	logic [1:0] mode_plan [8] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1, 2'd3};
	logic [1:0] fsel_plan [8] = '{2'd0, 2'd1, 2'd0, 2'd1, 2'd3, 2'd2, 2'd1, 2'd2};

	motion_adaptive_deinterlace_pixel u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.prev_column(prev_column),
		.next_column(next_column),
		.cur_above  (cur_above),
		.cur_below  (cur_below),
		.cur_column (cur_column),
		.done       (done),
		.pixel_out  (pixel_out)
	);

	deinterlace_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.prev_column(prev_column),
		.next_column(next_column),
		.cur_above  (cur_above),
		.cur_below  (cur_below),
		.cur_column (cur_column),
		.done       (done),
		.pixel_out  (pixel_out),
		.mismatches (mismatches),
		.in_flight  (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > TIMEOUT_CYCLES) begin
			$display("tb: errors");
			$finish;
		end
	end

	function automatic logic [7:0] sat8(input int v);
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Presents one pixel beat and holds it until accepted. Start stays high when the next
	// beat follows immediately, so it is never lowered and raised in the same step.
	task automatic send_pixel(input logic [39:0] pv, input logic [39:0] nx,
			input logic [55:0] ab, input logic [55:0] be, input logic [23:0] cc);
		int gap;
		start <= 1'b1;
		prev_column <= pv;
		next_column <= nx;
		cur_above <= ab;
		cur_below <= be;
		cur_column <= cc;
		do @(posedge clk); while (busy);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			cur_above <= 56'({$urandom, $urandom});
			prev_column <= 40'({$urandom, $urandom});
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (in_flight != 0);
	endtask

	task automatic write_reg(input logic idx, input logic [1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [1:0] md, input logic [1:0] fs);
		write_reg(REG_MODE, md);
		write_reg(REG_FIELD_SELECT, fs);
		cfg_valid <= 1'b0;
		cfg_data <= 2'($urandom);
	endtask

	task automatic send_directed();
		send_pixel('0, '0, '0, '0, '0);
		send_pixel('1, '1, '1, '1, '1);
		send_pixel({5{8'h55}}, {5{8'hAA}}, {7{8'h55}}, {7{8'hAA}}, {3{8'h55}});
		send_pixel({5{8'hAA}}, {5{8'h55}}, {7{8'hAA}}, {7{8'h55}}, {3{8'hAA}});
		// Diagonal edges that the offset -1 and -2 checks should pick, then their mirrors.
		send_pixel(40'h30_30_30_30_30, 40'h30_30_30_30_30, 56'h46_3C_32_28_1E_14_0A,
			56'h32_28_1E_14_0A_00_00, 24'h30_30_30);
		send_pixel(40'h30_30_30_30_30, 40'h30_30_30_30_30, 56'h46_3C_32_28_1E_14_0A,
			56'h1E_14_0A_C8_C8_C8_C8, 24'h30_30_30);
		send_pixel(40'h30_30_30_30_30, 40'h30_30_30_30_30, 56'h0A_14_1E_28_32_3C_46,
			56'h00_00_0A_14_1E_28_32, 24'h30_30_30);
		send_pixel(40'h30_30_30_30_30, 40'h30_30_30_30_30, 56'h0A_14_1E_28_32_3C_46,
			56'hC8_C8_C8_C8_0A_14_1E, 24'h30_30_30);
		// Bright spatial guess against dark still frames: the clamp bites unless the
		// spatial check widens the bound; then the same with the levels swapped.
		send_pixel(40'h00_FF_00_FF_00, 40'h00_FF_00_FF_00, '1, '1, '0);
		send_pixel(40'hFF_00_FF_00_FF, 40'hFF_00_FF_00_FF, '0, '0, '1);
		send_pixel('1, '0, {7{8'h80}}, {7{8'h80}}, {3{8'h80}});
		send_pixel(40'h12_C4_7E_03_F9, 40'hA0_0B_66_D2_31, 56'h9C_05_E7_40_2A_B8_71,
			56'h3F_D6_18_8D_F2_64_09, 24'hE1_5A_C3);
	endtask

	task automatic send_random_pixel();
		int kind, base, step, shift, spread, k;
		logic [39:0] pv, nx;
		logic [55:0] ab, be;
		logic [23:0] cc;
		kind = $urandom_range(0, 9);
		base = $urandom_range(0, 255);
		step = $urandom_range(0, 80) - 40;
		shift = $urandom_range(0, 3);
		shift = (shift < 2) ? shift - 2 : shift - 1;
		spread = (kind < 6) ? 2 : (kind < 8) ? 16 : 64;
		pv = 40'({$urandom, $urandom});
		nx = 40'({$urandom, $urandom});
		ab = 56'({$urandom, $urandom});
		be = 56'({$urandom, $urandom});
		cc = 24'($urandom);
		if (kind == 2) begin
			for (k = 0; k < 7; k++) begin
				ab[8 * k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				be[8 * k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			for (k = 0; k < 5; k++) begin
				pv[8 * k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				nx[8 * k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			for (k = 0; k < 3; k++)
				cc[8 * k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end else if (kind > 2) begin
			// Smooth picture: a flat area or a sloped edge along a random diagonal,
			// with the other frames within 2, 16 or 64 of the local level.
			if (kind == 3)
				step = $urandom_range(0, 6) - 3;
			for (k = 0; k < 7; k++) begin
				ab[8 * k +: 8] = sat8(base + (k - 3) * step + $urandom_range(0, 6) - 3);
				be[8 * k +: 8] = sat8(base + (k - 3 + 2 * shift) * step
					+ $urandom_range(0, 6) - 3);
			end
			for (k = 0; k < 5; k++) begin
				pv[8 * k +: 8] = sat8(base + $urandom_range(0, 2 * spread) - spread);
				nx[8 * k +: 8] = sat8(base + $urandom_range(0, 2 * spread) - spread);
			end
			for (k = 0; k < 3; k++)
				cc[8 * k +: 8] = sat8(base + $urandom_range(0, 2 * spread) - spread);
		end
		send_pixel(pv, nx, ab, be, cc);
	endtask

	initial begin
		int phase, n;
		arst_n <= 1'b0;
		start <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data <= '0;
		prev_column <= '0;
		next_column <= '0;
		cur_above <= '0;
		cur_below <= '0;
		cur_column <= '0;
		steady <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(2'd0, 2'd0);
		send_directed();
		start <= 1'b0;
		wait_idle();
		set_config(2'd3, 2'd1);
		send_directed();

		for (phase = 0; phase < PHASES; phase++) begin
			start <= 1'b0;
			wait_idle();
			steady <= (phase % 3 == 1);
			if (phase < 8)
				set_config(mode_plan[phase], fsel_plan[phase]);
			else
				set_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
			for (n = 0; n < PIXELS_PER_PHASE; n++)
				send_random_pixel();
		end

		start <= 1'b0;
		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/madi_pkg.sv
hw/rtl/madi_front.sv
hw/rtl/madi_select.sv
hw/rtl/madi_clamp.sv
hw/rtl/motion_adaptive_deinterlace_pixel.sv
tb/madi_tb_pkg.sv
tb/deinterlace_check.sv
tb/tb.sv
